### rtl/sqvg_pkg.sv
// sqvg_pkg: shared types, constants and the sine table for the sprite quad vertex generator
// depends on nothing; used by every file under rtl by scoped names
package sqvg_pkg;

  // sine table geometry
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_AW      = $clog2(SINE_ENTRIES);

  // fixed point widths
  localparam int TEX_W   = 13;  // texture size register
  localparam int TEXEL_W = 14;  // source edge plus span
  localparam int NUM_W   = 30;  // texel * 65536 plus rounding half
  localparam int UV_W    = 18;  // unsigned Q2.16
  localparam int POS_W   = 24;  // signed Q16.8
  localparam int TRIG_W  = 16;  // signed Q1.14
  localparam int CORN_W  = 17;  // pivot-relative corner factor, Q2.14
  localparam int DIM_W   = 30;  // scale * size
  localparam int ROT_W   = 46;  // dim * trig
  localparam int ACC_W   = 64;  // rotated corner before rounding

  localparam logic [TEX_W-1:0] TEX_SIZE_RST = 13'd256;
  localparam logic signed [CORN_W-1:0] ONE_Q14 = 17'sd16384;
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = 64'sd134217728;

  // register indexes of the configuration port
  localparam logic REG_TEX_W = 1'b0;
  localparam logic REG_TEX_H = 1'b1;

  // mode bits
  localparam int MODE_ROT90 = 0;
  localparam int MODE_FLIPH = 1;
  localparam int MODE_FLIPV = 2;
  localparam int MODE_WHOLE = 3;

  // vertices per quad, index of the closing vertex
  localparam logic [2:0] VTX_LAST = 3'd5;

  typedef struct packed {
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [12:0]        src_w;
    logic [12:0]        src_h;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        angle;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [31:0]        origin_xy;
    logic [3:0]         mode;
    logic [31:0]        color;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] vtx_x;
    logic signed [23:0] vtx_y;
    logic [17:0]        tex_u;
    logic [17:0]        tex_v;
    logic [31:0]        vtx_color;
    logic               last;
  } out_item_t;

  // position, color and last flag travelling beside the divider
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [31:0]        color;
    logic               last;
  } pos_item_t;

  // corner of the quad for each of the six triangle-list vertices
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0: c = 2'd0;
      3'd1: c = 2'd1;
      3'd2: c = 2'd2;
      3'd3: c = 2'd0;
      3'd4: c = 2'd2;
      3'd5: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // taylor series divisors (2i)(2i+1)
  localparam int TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sin(r/N * pi/2) in Q14
  function automatic logic signed [15:0] quarter_sine(input logic [63:0] r);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    theta = r * HALF_PI_Q30 / SINE_ENTRIES;
    t2    = (theta * theta) >> 30;
    term  = theta;
    sum   = theta;
    for (int i = 1; i <= 7; i++) begin
      term = ((term * t2) >> 30) / TAYLOR_DIV[i];
      if (i % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    return 16'((sum + 64'd32768) >> 16);
  endfunction

  typedef logic signed [TRIG_W-1:0] sine_tab_t [SINE_ENTRIES];

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] r;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      m = 64'(4 * k);
      q = m / SINE_ENTRIES;
      r = m % SINE_ENTRIES;
      case (q)
        64'd0:   tab[k] = quarter_sine(r);
        64'd1:   tab[k] = quarter_sine(64'(SINE_ENTRIES) - r);
        64'd2:   tab[k] = -quarter_sine(r);
        default: tab[k] = -quarter_sine(64'(SINE_ENTRIES) - r);
      endcase
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine();

endpackage

### rtl/sqvg_uv_div.sv
// sqvg_uv_div: pipelined restoring divider, one quotient bit per stage, saturating at UV max
// depends on sqvg_pkg for widths
module sqvg_uv_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sqvg_pkg::NUM_W-1:0]  num_i,
  input  logic [sqvg_pkg::TEX_W-1:0]  den_i,
  output logic [sqvg_pkg::UV_W-1:0]   quot_o
);

  localparam int NSTG = sqvg_pkg::UV_W;

  logic [sqvg_pkg::NUM_W-1:0] rem_r [NSTG];
  logic [sqvg_pkg::TEX_W-1:0] den_r [NSTG];
  logic [sqvg_pkg::UV_W-1:0]  q_r   [NSTG];
  logic                       sat_r [NSTG];

  logic [sqvg_pkg::NUM_W-1:0] rem_nxt [NSTG];
  logic [sqvg_pkg::TEX_W-1:0] den_nxt [NSTG];
  logic [sqvg_pkg::UV_W-1:0]  q_nxt   [NSTG];
  logic                       sat_nxt [NSTG];

  // one compare and subtract per stage
  always_comb begin
    logic [sqvg_pkg::NUM_W-1:0] rem_in;
    logic [sqvg_pkg::NUM_W-1:0] dsh;
    logic [sqvg_pkg::UV_W-1:0]  q_in;
    for (int j = 0; j < NSTG; j++) begin
      if (j == 0) begin
        rem_in     = num_i;
        den_nxt[j] = den_i;
        q_in       = '0;
        sat_nxt[j] = {1'b0, num_i} >= {den_i, 18'b0};
      end else begin
        rem_in     = rem_r[j-1];
        den_nxt[j] = den_r[j-1];
        q_in       = q_r[j-1];
        sat_nxt[j] = sat_r[j-1];
      end
      dsh = sqvg_pkg::NUM_W'(den_nxt[j]) << (NSTG - 1 - j);
      if (rem_in >= dsh) begin
        rem_nxt[j] = rem_in - dsh;
        q_nxt[j]   = q_in | (sqvg_pkg::UV_W'(1) << (NSTG - 1 - j));
      end else begin
        rem_nxt[j] = rem_in;
        q_nxt[j]   = q_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NSTG; j++) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= den_nxt[j];
        q_r[j]   <= q_nxt[j];
        sat_r[j] <= sat_nxt[j];
      end
    end
  end

  assign quot_o = sat_r[NSTG-1] ? '1 : q_r[NSTG-1];

endmodule

### rtl/sprite_quad_vertex_generator_core.sv
// sprite_quad_vertex_generator_core: top level, sprite request in, six triangle-list vertices out
// depends on sqvg_pkg and sqvg_uv_div
//
// Usage:
// - in channel (in_valid, in_stall, in_data): one sprite request per transfer.
// - out channel (out_valid, out_stall, out_data): six vertices per request in the order
//   v0,v1,v2,v0,v2,v3; out_data.last marks the sixth.
// - cfg port (cfg_wr_en, cfg_idx, cfg_wdata): index 0 texture width, index 1 texture height,
//   written only while no request is in flight.
// The first vertex of a request passes stage 1 and the divider stages before it is shown; the
// other five follow one per cycle while the receiver does not stall.
// Requests are paced by the vertex issue stage, which sends one vertex per cycle down a
// 19 stage pipeline while the pipeline advances; the next request is taken in the cycle the
// sixth vertex of the current one is issued.
// The pipeline is bounded by the 18 stage u/v dividers, one quotient bit per stage.
// Reset (rst_n low, synchronous) empties the pipeline and sets both texture sizes to 256.
// When the receiver stalls a shown vertex, the whole pipeline and the issue stage hold; nothing is lost
// or repeated, and in_stall rises once the issue stage is full.
module sprite_quad_vertex_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sqvg_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sqvg_pkg::out_item_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_idx,
  input  logic [sqvg_pkg::TEX_W-1:0]    cfg_wdata
);

  localparam int NSTG = 1 + sqvg_pkg::UV_W;  // stage 1 prep plus divider stages
  localparam int PSTG = 6;                   // stage holding the finished position
  localparam int DLY  = NSTG - PSTG;

  // configuration registers
  logic [sqvg_pkg::TEX_W-1:0] tw_r, th_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= sqvg_pkg::TEX_SIZE_RST;
      th_r <= sqvg_pkg::TEX_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        sqvg_pkg::REG_TEX_W: tw_r <= cfg_wdata;
        sqvg_pkg::REG_TEX_H: th_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance: the output register is free or being taken
  logic vld_r [1:NSTG];
  logic adv;
  assign adv = !vld_r[NSTG] || !out_stall;

  // issue stage: holds one request and sends its six vertices
  sqvg_pkg::in_item_t item_r;
  logic               busy_r;
  logic [2:0]         k_r;
  logic               in_xfer;

  assign in_stall = busy_r && !(adv && k_r == sqvg_pkg::VTX_LAST);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (in_xfer) begin
      busy_r <= 1'b1;
      k_r    <= '0;
    end else if (adv && busy_r) begin
      if (k_r == sqvg_pkg::VTX_LAST) busy_r <= 1'b0;
      k_r <= k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) item_r <= in_data;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NSTG; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[1] <= busy_r;
      for (int s = 2; s <= NSTG; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // stage 1: corner select, texel edges, table read, scaled size
  logic [sqvg_pkg::TEX_W-1:0]   tw_eff, th_eff;
  logic [1:0]                   c_pos, c_uv;
  logic [11:0]                  sx, sy;
  logic [12:0]                  sw, sh;
  logic [sqvg_pkg::TEXEL_W-1:0] tu, tv;
  logic [15:0]                  cos_ph;
  logic signed [15:0]           ox, oy;

  logic [sqvg_pkg::NUM_W-1:0]          num_u_nxt, num_v_nxt;
  logic signed [sqvg_pkg::DIM_W-1:0]   dw_nxt, dh_nxt;
  logic signed [sqvg_pkg::CORN_W-1:0]  cx_nxt, cy_nxt;

  always_comb begin
    tw_eff = (tw_r == '0) ? sqvg_pkg::TEX_W'(1) : tw_r;
    th_eff = (th_r == '0) ? sqvg_pkg::TEX_W'(1) : th_r;
    c_pos  = sqvg_pkg::corner_of(k_r);
    c_uv   = c_pos ^ {item_r.mode[sqvg_pkg::MODE_FLIPV],
                      item_r.mode[sqvg_pkg::MODE_FLIPV] ^ item_r.mode[sqvg_pkg::MODE_FLIPH]};
    if (item_r.mode[sqvg_pkg::MODE_WHOLE]) begin
      sx = '0;
      sy = '0;
      sw = tw_eff;
      sh = th_eff;
    end else begin
      sx = item_r.src_x;
      sy = item_r.src_y;
      sw = item_r.src_w;
      sh = item_r.src_h;
    end
    // texel corner of the source rectangle
    if (item_r.mode[sqvg_pkg::MODE_ROT90]) begin
      tu = (c_uv == 2'd0 || c_uv == 2'd1) ? 14'(sx) + 14'(sh) : 14'(sx);
      tv = (c_uv == 2'd1 || c_uv == 2'd2) ? 14'(sy) + 14'(sw) : 14'(sy);
    end else begin
      tu = (c_uv == 2'd1 || c_uv == 2'd2) ? 14'(sx) + 14'(sw) : 14'(sx);
      tv = (c_uv == 2'd2 || c_uv == 2'd3) ? 14'(sy) + 14'(sh) : 14'(sy);
    end
    num_u_nxt = {tu, 16'b0} + sqvg_pkg::NUM_W'(tw_eff >> 1);
    num_v_nxt = {tv, 16'b0} + sqvg_pkg::NUM_W'(th_eff >> 1);
    cos_ph    = item_r.angle + 16'd16384;
    dw_nxt    = item_r.scale_x * $signed({1'b0, sw});
    dh_nxt    = item_r.scale_y * $signed({1'b0, sh});
    ox        = $signed(item_r.origin_xy[15:0]);
    oy        = $signed(item_r.origin_xy[31:16]);
    cx_nxt    = (c_pos == 2'd1 || c_pos == 2'd2) ? sqvg_pkg::ONE_Q14 - 17'(ox) : -17'(ox);
    cy_nxt    = (c_pos == 2'd2 || c_pos == 2'd3) ? sqvg_pkg::ONE_Q14 - 17'(oy) : -17'(oy);
  end

  logic [sqvg_pkg::NUM_W-1:0]          num_u_r, num_v_r;
  logic [sqvg_pkg::TEX_W-1:0]          tw1_r, th1_r;
  logic signed [sqvg_pkg::TRIG_W-1:0]  sn1_r, cs1_r;
  logic signed [sqvg_pkg::DIM_W-1:0]   dw1_r, dh1_r;
  logic signed [sqvg_pkg::CORN_W-1:0]  cx1_r, cy1_r;
  logic signed [sqvg_pkg::POS_W-1:0]   px1_r, py1_r;
  logic [31:0]                         col1_r;
  logic                                last1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      num_u_r <= num_u_nxt;
      num_v_r <= num_v_nxt;
      tw1_r   <= tw_eff;
      th1_r   <= th_eff;
      sn1_r   <= sqvg_pkg::SINE_ROM[item_r.angle[15 -: sqvg_pkg::SINE_AW]];
      cs1_r   <= sqvg_pkg::SINE_ROM[cos_ph[15 -: sqvg_pkg::SINE_AW]];
      dw1_r   <= dw_nxt;
      dh1_r   <= dh_nxt;
      cx1_r   <= cx_nxt;
      cy1_r   <= cy_nxt;
      px1_r   <= item_r.pos_x;
      py1_r   <= item_r.pos_y;
      col1_r  <= item_r.color;
      last1_r <= (k_r == sqvg_pkg::VTX_LAST);
    end
  end

  // stage 2: size times sine and cosine
  logic signed [sqvg_pkg::ROT_W-1:0]   a1_r, a2_r, b1_r, b2_r;
  logic signed [sqvg_pkg::CORN_W-1:0]  cx2_r, cy2_r;
  logic signed [sqvg_pkg::POS_W-1:0]   px2_r, py2_r;
  logic [31:0]                         col2_r;
  logic                                last2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r    <= dw1_r * cs1_r;
      a2_r    <= dw1_r * sn1_r;
      b1_r    <= dh1_r * sn1_r;
      b2_r    <= dh1_r * cs1_r;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
      px2_r   <= px1_r;
      py2_r   <= py1_r;
      col2_r  <= col1_r;
      last2_r <= last1_r;
    end
  end

  // stage 3: corner factor times rotated size, split in low and high partial products
  logic signed [40:0] pl_a1_r, pl_a2_r, pl_b1_r, pl_b2_r;
  logic signed [39:0] ph_a1_r, ph_a2_r, ph_b1_r, ph_b2_r;
  logic signed [sqvg_pkg::POS_W-1:0] px3_r, py3_r;
  logic [31:0]                       col3_r;
  logic                              last3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_a1_r <= $signed({1'b0, a1_r[22:0]}) * cx2_r;
      pl_a2_r <= $signed({1'b0, a2_r[22:0]}) * cx2_r;
      pl_b1_r <= $signed({1'b0, b1_r[22:0]}) * cy2_r;
      pl_b2_r <= $signed({1'b0, b2_r[22:0]}) * cy2_r;
      ph_a1_r <= $signed(a1_r[45:23]) * cx2_r;
      ph_a2_r <= $signed(a2_r[45:23]) * cx2_r;
      ph_b1_r <= $signed(b1_r[45:23]) * cy2_r;
      ph_b2_r <= $signed(b2_r[45:23]) * cy2_r;
      px3_r   <= px2_r;
      py3_r   <= py2_r;
      col3_r  <= col2_r;
      last3_r <= last2_r;
    end
  end

  // stage 4: recombine partial products
  logic signed [sqvg_pkg::ACC_W-1:0] ta1_r, ta2_r, tb1_r, tb2_r;
  logic signed [sqvg_pkg::POS_W-1:0] px4_r, py4_r;
  logic [31:0]                       col4_r;
  logic                              last4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ta1_r   <= (64'(ph_a1_r) <<< 23) + 64'(pl_a1_r);
      ta2_r   <= (64'(ph_a2_r) <<< 23) + 64'(pl_a2_r);
      tb1_r   <= (64'(ph_b1_r) <<< 23) + 64'(pl_b1_r);
      tb2_r   <= (64'(ph_b2_r) <<< 23) + 64'(pl_b2_r);
      px4_r   <= px3_r;
      py4_r   <= py3_r;
      col4_r  <= col3_r;
      last4_r <= last3_r;
    end
  end

  // stage 5: rotation sums with rounding half
  logic signed [sqvg_pkg::ACC_W-1:0] sum_x_r, sum_y_r;
  logic signed [sqvg_pkg::POS_W-1:0] px5_r, py5_r;
  logic [31:0]                       col5_r;
  logic                              last5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_x_r <= ta1_r - tb1_r + sqvg_pkg::ROUND_HALF;
      sum_y_r <= ta2_r + tb2_r + sqvg_pkg::ROUND_HALF;
      px5_r   <= px4_r;
      py5_r   <= py4_r;
      col5_r  <= col4_r;
      last5_r <= last4_r;
    end
  end

  // stage 6: drop fraction, translate, saturate
  function automatic logic signed [23:0] sat_pos(input logic signed [32:0] v);
    logic signed [23:0] r;
    if (v > 33'sd8388607)       r = 24'sh7fffff;
    else if (v < -33'sd8388608) r = 24'sh800000;
    else                        r = v[23:0];
    return r;
  endfunction

  logic signed [31:0] rx, ry;
  logic signed [32:0] tx, ty;
  sqvg_pkg::pos_item_t pos_nxt;

  always_comb begin
    rx = 32'(sum_x_r >>> 28);
    ry = 32'(sum_y_r >>> 28);
    tx = 33'(rx) + 33'(px5_r);
    ty = 33'(ry) + 33'(py5_r);
    pos_nxt.x     = sat_pos(tx);
    pos_nxt.y     = sat_pos(ty);
    pos_nxt.color = col5_r;
    pos_nxt.last  = last5_r;
  end

  // delay line to meet the divider output
  sqvg_pkg::pos_item_t pdly_r [DLY+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      pdly_r[0] <= pos_nxt;
      for (int s = 1; s <= DLY; s++) pdly_r[s] <= pdly_r[s-1];
    end
  end

  // texture coordinate dividers, stages 2 to 19
  logic [sqvg_pkg::UV_W-1:0] u_q, v_q;

  sqvg_uv_div u_div_u (
    .clk    (clk),
    .en     (adv),
    .num_i  (num_u_r),
    .den_i  (tw1_r),
    .quot_o (u_q)
  );

  sqvg_uv_div u_div_v (
    .clk    (clk),
    .en     (adv),
    .num_i  (num_v_r),
    .den_i  (th1_r),
    .quot_o (v_q)
  );

  // output register is the last stage
  assign out_valid = vld_r[NSTG];

  always_comb begin
    out_data.vtx_x     = pdly_r[DLY].x;
    out_data.vtx_y     = pdly_r[DLY].y;
    out_data.tex_u     = u_q;
    out_data.tex_v     = v_q;
    out_data.vtx_color = pdly_r[DLY].color;
    out_data.last      = pdly_r[DLY].last;
  end

endmodule

### rtl/sqvg_checker.sv
// sqvg_checker: port-level checks for the sprite quad vertex generator, bound to the top level
// depends on sqvg_pkg and sprite_quad_vertex_generator_core
module sqvg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input sqvg_pkg::out_item_t           out_data
);

  // a stalled vertex stays and does not change
  a_out_hold: assert property (@(posedge clk)
    rst_n && out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled vertex dropped or changed");

  // a request transfer fills the issue stage for its remaining vertices
  a_in_busy: assert property (@(posedge clk)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still issuing");

  // reset empties the block
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // the closing vertex of a request is never directly followed by another closing vertex
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !(out_valid && out_data.last))
    else $error("two closing vertices back to back");

endmodule

bind sprite_quad_vertex_generator_core sqvg_checker u_sqvg_checker (.*);
